// File: rtl/jsms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON member splitter package
// Shared constants, byte classes and the types passed between the front part,
// the item queue and the back part.
// ----------------------------------------------------------------------------
package jsms_pkg;

    // Widths of the result fields and of the scan state.
    localparam int FIELD_W = 16;
    localparam int POS_W   = FIELD_W + 1;
    localparam int DEPTH_W = 8;

    // Text positions run from 0 up to TEXT_LIMIT; a byte at TEXT_LIMIT is not scanned.
    localparam logic [POS_W-1:0]   TEXT_LIMIT = POS_W'(65536);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = DEPTH_W'(255);

    // Item queue between the front and the back part.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Byte values that matter to the scanner.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;

    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_BACKSLASH,
        CLS_QUOTE,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_LBRACKET,
        CLS_RBRACKET,
        CLS_COLON,
        CLS_COMMA
    } char_class_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_FRAMING = 2'd1,
        ERR_DEPTH   = 2'd2
    } err_code_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        char_class_t cls;
        logic        last;
    } item_t;

    // Queue status seen by the front and the back part.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage : jsms_pkg
`default_nettype wire

// File: rtl/json_object_member_splitter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON object member splitter
// Splits the bytes of one JSON object into key and value offsets and lengths.
// ----------------------------------------------------------------------------
// A result item passes through the item queue and then the result register.
// Throughput: one byte per cycle, set by the back part's scan state update;
// a result held by a stalled output stops it once the four-entry queue fills.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the scan
// state and drops any pending result.
// ----------------------------------------------------------------------------
//
// The front part classifies each byte into one of the characters that matter
// (quote, backslash, braces, brackets, colon, comma) and pushes the class with
// the last-byte flag into a short queue. Its stall follows only the queue's
// registered fill level, so it never waits on the output directly.
//
// The back part pops one item per cycle and updates the escape, string and
// depth tracking. At depth zero it captures each quoted key and the value that
// starts after the colon. A comma at depth zero outside a string ends a member
// and produces a result item; the last byte always produces one, marked with
// object_end, and returns the scanner to its reset state. Only an item that
// makes a result waits while the output register holds a stalled result.
//
// The first and last byte only frame the object. Bad framing, an over-long
// text and depth overflow or underflow set a sticky error code that each result
// from that byte to the end of the object carries.
module json_object_member_splitter_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    char_valid,
    output logic                         char_stall,
    input  wire logic [7:0]              char_byte,
    input  wire logic                    last_char,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output logic                         member_valid,
    output logic [jsms_pkg::FIELD_W-1:0] key_offset,
    output logic [jsms_pkg::FIELD_W-1:0] key_length,
    output logic [jsms_pkg::FIELD_W-1:0] value_offset,
    output logic [jsms_pkg::FIELD_W-1:0] value_length,
    output logic                         object_end,
    output logic [1:0]                   error_code
);
    import jsms_pkg::*;

    queue_status_t q_status;
    item_t         push_item;
    item_t         head_item;
    logic          push;
    logic          pop;

    jsms_front u_front (
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_byte  (char_byte),
        .last_char  (last_char),
        .q_status   (q_status),
        .push       (push),
        .push_item  (push_item)
    );

    jsms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    jsms_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .member_valid (member_valid),
        .key_offset   (key_offset),
        .key_length   (key_length),
        .value_offset (value_offset),
        .value_length (value_length),
        .object_end   (object_end),
        .error_code   (error_code)
    );

endmodule : json_object_member_splitter_core
`default_nettype wire

// File: rtl/jsms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON member splitter front part
// Accepts bytes, sorts each into a character class and pushes it to the queue.
// ----------------------------------------------------------------------------
module jsms_front (
    input  wire logic                    char_valid,
    output logic                         char_stall,
    input  wire logic [7:0]              char_byte,
    input  wire logic                    last_char,
    input  wire jsms_pkg::queue_status_t q_status,
    output logic                         push,
    output jsms_pkg::item_t              push_item
);
    import jsms_pkg::*;

    char_class_t cls;

    always_comb
    begin
        case (char_byte)
            CH_BACKSLASH: cls = CLS_BACKSLASH;
            CH_QUOTE:     cls = CLS_QUOTE;
            CH_LBRACE:    cls = CLS_LBRACE;
            CH_RBRACE:    cls = CLS_RBRACE;
            CH_LBRACKET:  cls = CLS_LBRACKET;
            CH_RBRACKET:  cls = CLS_RBRACKET;
            CH_COLON:     cls = CLS_COLON;
            CH_COMMA:     cls = CLS_COMMA;
            default:      cls = CLS_OTHER;
        endcase
    end

    // The stall comes from the registered fill level only.
    assign char_stall     = q_status.full;
    assign push           = char_valid && !q_status.full;
    assign push_item.cls  = cls;
    assign push_item.last = last_char;

endmodule : jsms_front
`default_nettype wire

// File: rtl/jsms_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON member splitter item queue
// A short first-in first-out queue of classified items.
// ----------------------------------------------------------------------------
module jsms_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire jsms_pkg::item_t         push_item,
    input  wire logic                    pop,
    output jsms_pkg::item_t              head_item,
    output jsms_pkg::queue_status_t      q_status
);
    import jsms_pkg::*;

    item_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item      = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    // The fill level tracks the pointer distance.
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0])
        else $error("queue fill level disagrees with pointers");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

endmodule : jsms_queue
`default_nettype wire

// File: rtl/jsms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON member splitter back part
// Runs the scan state for each classified item and registers the results.
// ----------------------------------------------------------------------------
module jsms_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire jsms_pkg::item_t         head_item,
    input  wire jsms_pkg::queue_status_t q_status,
    output logic                         pop,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output logic                         member_valid,
    output logic [jsms_pkg::FIELD_W-1:0] key_offset,
    output logic [jsms_pkg::FIELD_W-1:0] key_length,
    output logic [jsms_pkg::FIELD_W-1:0] value_offset,
    output logic [jsms_pkg::FIELD_W-1:0] value_length,
    output logic                         object_end,
    output logic [1:0]                   error_code
);
    import jsms_pkg::*;

    // Scan state.
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [DEPTH_W-1:0] brace_reg,     brace_next;
    logic [DEPTH_W-1:0] bracket_reg,   bracket_next;
    logic               in_string_reg, in_string_next;
    logic               escape_reg,    escape_next;
    logic               in_value_reg,  in_value_next;
    logic [FIELD_W-1:0] token_reg,     token_next;
    logic [FIELD_W-1:0] key_off_reg,   key_off_next;
    logic [FIELD_W-1:0] key_len_reg,   key_len_next;
    err_code_t          err_reg,       err_next;

    // Result register.
    logic               out_valid_reg;
    logic               out_member_reg;
    logic [FIELD_W-1:0] out_key_off_reg;
    logic [FIELD_W-1:0] out_key_len_reg;
    logic [FIELD_W-1:0] out_val_off_reg;
    logic [FIELD_W-1:0] out_val_len_reg;
    logic               out_end_reg;
    err_code_t          out_err_reg;

    logic               fire;
    logic               make_result;
    logic               res_member;
    logic [FIELD_W-1:0] res_val_len;
    logic               in_range;
    logic               first;
    logic               top;
    logic               scan;
    logic               framing_err;
    logic               depth_err;
    logic               comma_hit;
    logic [FIELD_W-1:0] pos_low;

    always_comb
    begin
        pos_low     = pos_reg[FIELD_W-1:0];
        in_range    = (pos_reg < TEXT_LIMIT);
        first       = (pos_reg == '0);
        top         = (brace_reg == '0) && (bracket_reg == '0);
        scan        = in_range && !first && !head_item.last;
        framing_err = !in_range || (first && head_item.cls != CLS_LBRACE)
                      || (head_item.last && head_item.cls != CLS_RBRACE);
        comma_hit   = scan && head_item.cls == CLS_COMMA && !in_string_reg && top
                      && in_value_reg;
        make_result = head_item.last || comma_hit;
        fire        = !q_status.empty && (!make_result || !out_valid_reg || !result_stall);

        depth_err      = 1'b0;
        pos_next       = pos_reg;
        brace_next     = brace_reg;
        bracket_next   = bracket_reg;
        in_string_next = in_string_reg;
        escape_next    = escape_reg;
        in_value_next  = in_value_reg;
        token_next     = token_reg;
        key_off_next   = key_off_reg;
        key_len_next   = key_len_reg;

        if (scan)
        begin
            escape_next = !escape_reg && head_item.cls == CLS_BACKSLASH;
            case (head_item.cls)
                CLS_QUOTE:
                begin
                    if (!escape_reg)
                    begin
                        if (top && !in_value_reg)
                        begin
                            if (!in_string_reg)
                            begin
                                token_next = pos_low;
                            end
                            else
                            begin
                                key_off_next = token_reg + FIELD_W'(1);
                                key_len_next = pos_low - token_reg - FIELD_W'(1);
                            end
                        end
                        in_string_next = !in_string_reg;
                    end
                end
                CLS_LBRACE:
                begin
                    if (!in_string_reg)
                    begin
                        if (brace_reg >= DEPTH_MAX)
                            depth_err = 1'b1;
                        else
                            brace_next = brace_reg + DEPTH_W'(1);
                    end
                end
                CLS_RBRACE:
                begin
                    if (!in_string_reg)
                    begin
                        if (brace_reg == '0)
                            depth_err = 1'b1;
                        else
                            brace_next = brace_reg - DEPTH_W'(1);
                    end
                end
                CLS_LBRACKET:
                begin
                    if (!in_string_reg)
                    begin
                        if (bracket_reg >= DEPTH_MAX)
                            depth_err = 1'b1;
                        else
                            bracket_next = bracket_reg + DEPTH_W'(1);
                    end
                end
                CLS_RBRACKET:
                begin
                    if (!in_string_reg)
                    begin
                        if (bracket_reg == '0)
                            depth_err = 1'b1;
                        else
                            bracket_next = bracket_reg - DEPTH_W'(1);
                    end
                end
                CLS_COLON:
                begin
                    if (!in_string_reg && top)
                    begin
                        in_value_next = 1'b1;
                        token_next    = pos_low + FIELD_W'(1);
                    end
                end
                CLS_COMMA:
                begin
                    if (comma_hit)
                        in_value_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        // The first error of an object sticks; framing wins over a depth error on the same byte.
        if (err_reg != ERR_NONE)
            err_next = err_reg;
        else if (framing_err)
            err_next = ERR_FRAMING;
        else if (depth_err)
            err_next = ERR_DEPTH;
        else
            err_next = ERR_NONE;

        if (in_range)
            pos_next = pos_reg + POS_W'(1);

        res_member  = head_item.last ? in_value_reg : 1'b1;
        res_val_len = pos_low - token_reg;

        // The last byte reports and then returns every state to reset.
        if (head_item.last)
        begin
            pos_next       = '0;
            brace_next     = '0;
            bracket_next   = '0;
            in_string_next = 1'b0;
            escape_next    = 1'b0;
            in_value_next  = 1'b0;
            token_next     = '0;
            key_off_next   = '0;
            key_len_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            brace_reg     <= '0;
            bracket_reg   <= '0;
            in_string_reg <= 1'b0;
            escape_reg    <= 1'b0;
            in_value_reg  <= 1'b0;
            token_reg     <= '0;
            key_off_reg   <= '0;
            key_len_reg   <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                pos_reg       <= pos_next;
                brace_reg     <= brace_next;
                bracket_reg   <= bracket_next;
                in_string_reg <= in_string_next;
                escape_reg    <= escape_next;
                in_value_reg  <= in_value_next;
                token_reg     <= token_next;
                key_off_reg   <= key_off_next;
                key_len_reg   <= key_len_next;
                err_reg       <= head_item.last ? ERR_NONE : err_next;
            end
            if (fire && make_result)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && make_result)
        begin
            out_member_reg  <= res_member;
            out_key_off_reg <= res_member ? key_off_reg : '0;
            out_key_len_reg <= res_member ? key_len_reg : '0;
            out_val_off_reg <= res_member ? token_reg : '0;
            out_val_len_reg <= res_member ? res_val_len : '0;
            out_end_reg     <= head_item.last;
            out_err_reg     <= err_next;
        end
    end

    assign pop          = fire;
    assign result_valid = out_valid_reg;
    assign member_valid = out_member_reg;
    assign key_offset   = out_key_off_reg;
    assign key_length   = out_key_len_reg;
    assign value_offset = out_val_off_reg;
    assign value_length = out_val_len_reg;
    assign object_end   = out_end_reg;
    assign error_code   = out_err_reg;

    // The end of an object leaves the scanner in its reset state.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && head_item.last) |=> (pos_reg == '0 && brace_reg == '0
            && bracket_reg == '0 && !in_value_reg && err_reg == ERR_NONE))
        else $error("scan state not cleared after last byte");

    // A raised error holds until the object ends.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE && !(fire && head_item.last)) |=> err_reg == $past(err_reg))
        else $error("sticky error changed inside an object");

    // A result without a member carries zero offsets and lengths.
    a_empty_member: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !member_valid) |-> (key_offset == '0 && key_length == '0
            && value_offset == '0 && value_length == '0))
        else $error("non-member result carries offsets");

endmodule : jsms_back
`default_nettype wire
